### src/bpa_pkg.sv
// shared constants and codes for the two-pool bitmap page allocator
`default_nettype none
package bpa_pkg;
	localparam int PAGE_W         = 20;
	localparam int CNT_W          = 11;
	localparam int STAT_W         = 3;
	localparam int WORD_BITS      = 16;
	localparam int WORD_LG        = 4;
	localparam int POOL_PAGES_DEF = 1024;
	localparam int APB_AW         = 4;
	localparam int APB_DW         = 32;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
	localparam logic [STAT_W-1:0] ST_NOSPACE = 3'd1;
	localparam logic [STAT_W-1:0] ST_IGNORED = 3'd2;
	localparam logic [STAT_W-1:0] ST_OUTSIDE = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOTUSED = 3'd4;

	// request operations
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// register indexes
	localparam logic [1:0] REG_KBASE  = 2'd0;
	localparam logic [1:0] REG_KPAGES = 2'd1;
	localparam logic [1:0] REG_UBASE  = 2'd2;
	localparam logic [1:0] REG_UPAGES = 2'd3;
endpackage
`default_nettype wire

### src/bpa_if.sv
// request and response channel interfaces
`default_nettype none
interface bpa_req_if;
	logic                            valid;
	logic                            ready;
	logic                            op;
	logic                            from_user_pool;
	logic [bpa_pkg::CNT_W-1:0]       page_count;
	logic [bpa_pkg::PAGE_W-1:0]      page_number;
	logic                            panic_on_fail;

	modport source (output valid, op, from_user_pool, page_count, page_number, panic_on_fail,
		input ready);
	modport sink (input valid, op, from_user_pool, page_count, page_number, panic_on_fail,
		output ready);
endinterface

interface bpa_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [bpa_pkg::STAT_W-1:0]      status;
	logic [bpa_pkg::PAGE_W-1:0]      first_page;
	logic                            panic;

	modport source (output valid, status, first_page, panic, input ready);
	modport sink (input valid, status, first_page, panic, output ready);
endinterface
`default_nettype wire

### src/bpa_cell.sv
// one page cell of the first-fit run scanner
`default_nettype none
module bpa_cell #(
	parameter int SW = 12
) (
	input  wire logic          used,
	input  wire logic [SW-1:0] idx,
	input  wire logic [SW-1:0] size,
	input  wire logic [SW-1:0] cnt,
	input  wire logic [SW-1:0] start_in,
	output logic      [SW-1:0] start_out,
	output logic               hit
);
	logic used_eff;

	// pages beyond the pool size count as used
	assign used_eff  = used | (idx >= size);
	// a used page restarts the run just after itself
	assign start_out = used_eff ? (idx + SW'(1)) : start_in;
	// run reaches the requested count at this page
	assign hit       = !used_eff && ((idx + SW'(1)) >= (start_in + cnt));
endmodule
`default_nettype wire

### src/bpa_row.sv
// row of page cells covering one bitmap word
`default_nettype none
module bpa_row #(
	parameter int SW = 12
) (
	input  wire logic [bpa_pkg::WORD_BITS-1:0] word,
	input  wire logic [SW-1:0]                 base_idx,
	input  wire logic [SW-1:0]                 size,
	input  wire logic [SW-1:0]                 cnt,
	input  wire logic [SW-1:0]                 start_in,
	output logic      [SW-1:0]                 start_out,
	output logic                               hit,
	output logic      [SW-1:0]                 hit_start
);
	localparam int WB = bpa_pkg::WORD_BITS;

	logic [SW-1:0] chain [WB+1];
	logic [SW-1:0] cell_start [WB];
	logic [WB-1:0] cell_hit;

	assign chain[0] = start_in;

	// run start handed from cell to cell
	for (genvar j = 0; j < WB; j++) begin : g_cell
		assign cell_start[j] = chain[j];
		bpa_cell #(.SW(SW)) u_cell (
			.used      (word[j]),
			.idx       (base_idx + SW'(j)),
			.size      (size),
			.cnt       (cnt),
			.start_in  (chain[j]),
			.start_out (chain[j+1]),
			.hit       (cell_hit[j])
		);
	end

	assign start_out = chain[WB];
	assign hit       = |cell_hit;

	// lowest hitting cell wins
	always_comb begin
		hit_start = '0;
		for (int j = WB - 1; j >= 0; j--) begin
			if (cell_hit[j]) begin
				hit_start = cell_start[j];
			end
		end
	end
endmodule
`default_nettype wire

### src/two_pool_bitmap_page_allocator.sv
// top level: two-pool first-fit page allocator with bitmap memory and scan row
// One request is handled at a time. After reset a clearing pass writes the bitmap memory one
// word a cycle over all 2*2^WA words (WA = word address bits, 128 words for 1024 pages) and no
// request is taken meanwhile. An allocate reads one 16-page bitmap word per cycle through a
// row of page cells until a run fits or the last word is read, then a marking pass sets the
// pages in each word touched; a free runs a check pass and a clearing pass of the same
// kind. Ignored, oversized and out-of-pool requests skip the scan and go to done. The response
// sits in an output register, so a new request is taken while the previous answer waits.
`default_nettype none
module two_pool_bitmap_page_allocator #(
	parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bpa_pkg::APB_AW-1:0]  paddr,
	input  wire logic [bpa_pkg::APB_DW-1:0]  pwdata,
	output logic      [bpa_pkg::APB_DW-1:0]  prdata,
	output logic                             pready,
	bpa_req_if.sink                          req,
	bpa_rsp_if.source                        rsp
);
	localparam int PW = bpa_pkg::PAGE_W;
	localparam int CW = bpa_pkg::CNT_W;
	localparam int WB = bpa_pkg::WORD_BITS;
	localparam int WL = bpa_pkg::WORD_LG;
	localparam int IW = $clog2(POOL_PAGES) + 1;
	localparam int SW = ((IW > CW) ? IW : CW) + 1;
	localparam int NW = (POOL_PAGES + WB - 1) / WB;
	localparam int WA = (NW > 1) ? $clog2(NW) : 1;
	localparam int MA = WA + 1;
	localparam int FW = PW + 1;

	// controller states
	localparam logic [2:0] S_CLR    = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_DEC    = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_RSTART = 3'd4;
	localparam logic [2:0] S_RANGE  = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	// range pass modes
	localparam logic [1:0] M_CHECK = 2'd0;
	localparam logic [1:0] M_SET   = 2'd1;
	localparam logic [1:0] M_CLEAR = 2'd2;

	logic [PW-1:0] kbase_q, ubase_q;
	logic [CW-1:0] kpages_q, upages_q;

	logic [2:0]    state_q, state_d;
	logic [1:0]    mode_q;
	logic [MA-1:0] clr_q;
	logic [WA-1:0] wc_q;
	logic          proc_valid_s1;
	logic [WA-1:0] proc_word_s1;
	logic [WB-1:0] rd_data_s1;
	logic [SW-1:0] run_start_q;
	logic [SW-1:0] s_q, e_q;
	logic          bad_q;

	logic          op_q, user_q, pan_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] pnum_q;

	logic [bpa_pkg::STAT_W-1:0] res_status_q;
	logic [PW-1:0]              res_first_q;
	logic                       res_panic_q;
	logic                       rsp_valid_q;
	logic [bpa_pkg::STAT_W-1:0] rsp_status_q;
	logic [PW-1:0]              rsp_first_q;
	logic                       rsp_panic_q;

	logic [WB-1:0] mem [2**MA];
	logic          mem_we;
	logic [MA-1:0] mem_wa;
	logic [WB-1:0] mem_wd;
	logic [MA-1:0] rd_addr;

	logic [PW-1:0] base_sel;
	logic [CW-1:0] size_raw;
	logic [SW-1:0] size_eff;
	logic [SW-1:0] cnt_w;
	logic [WA-1:0] last_word, ws, we;
	logic [WB-1:0] mask;
	logic          bad_now;
	logic          slot_free;
	logic          row_hit;
	logic [SW-1:0] row_start_out, row_hit_start;
	logic          cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kbase_q  <= '0;
			kpages_q <= '0;
			ubase_q  <= '0;
			upages_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				bpa_pkg::REG_KBASE:  kbase_q  <= pwdata[PW-1:0];
				bpa_pkg::REG_KPAGES: kpages_q <= pwdata[CW-1:0];
				bpa_pkg::REG_UBASE:  ubase_q  <= pwdata[PW-1:0];
				bpa_pkg::REG_UPAGES: upages_q <= pwdata[CW-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			bpa_pkg::REG_KBASE:  prdata = 32'(kbase_q);
			bpa_pkg::REG_KPAGES: prdata = 32'(kpages_q);
			bpa_pkg::REG_UBASE:  prdata = 32'(ubase_q);
			bpa_pkg::REG_UPAGES: prdata = 32'(upages_q);
		endcase
	end

	// selected pool view
	assign base_sel  = user_q ? ubase_q : kbase_q;
	assign size_raw  = user_q ? upages_q : kpages_q;
	assign size_eff  = (SW'(size_raw) > SW'(POOL_PAGES)) ? SW'(POOL_PAGES) : SW'(size_raw);
	assign cnt_w     = SW'(cnt_q);
	assign last_word = WA'((size_eff - SW'(1)) >> WL);
	assign ws        = WA'(s_q >> WL);
	assign we        = WA'(e_q >> WL);

	// scan row over the word just read
	bpa_row #(.SW(SW)) u_row (
		.word      (rd_data_s1),
		.base_idx  (SW'(proc_word_s1) << WL),
		.size      (size_eff),
		.cnt       (cnt_w),
		.start_in  (run_start_q),
		.start_out (row_start_out),
		.hit       (row_hit),
		.hit_start (row_hit_start)
	);

	// page mask of the range inside the word being processed
	always_comb begin
		for (int j = 0; j < WB; j++) begin
			mask[j] = ((proc_word_s1 != ws) || (WL'(j) >= s_q[WL-1:0])) &&
				((proc_word_s1 != we) || (WL'(j) <= e_q[WL-1:0]));
		end
	end
	assign bad_now = (rd_data_s1 & mask) != mask;

	// bitmap memory, pool selects the upper address bit
	assign rd_addr = {user_q, wc_q};
	assign mem_we  = (state_q == S_CLR) ||
		((state_q == S_RANGE) && proc_valid_s1 && (mode_q != M_CHECK));
	assign mem_wa  = (state_q == S_CLR) ? clr_q : {user_q, proc_word_s1};
	assign mem_wd  = (state_q == S_CLR) ? '0 :
		((mode_q == M_SET) ? (rd_data_s1 | mask) : (rd_data_s1 & ~mask));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	assign slot_free = !rsp_valid_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				if (&clr_q) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req.valid) state_d = S_DEC;
			end
			S_DEC: begin
				if (op_q == bpa_pkg::OP_ALLOC) begin
					if ((cnt_q == '0) || (cnt_w > size_eff)) state_d = S_DONE;
					else state_d = S_SCAN;
				end else begin
					if ((cnt_q == '0) || (pnum_q == '0) || (pnum_q < base_sel) ||
						((FW'(pnum_q) + FW'(cnt_q)) > (FW'(base_sel) + FW'(size_eff))))
						state_d = S_DONE;
					else state_d = S_RSTART;
				end
			end
			S_SCAN: begin
				if (proc_valid_s1) begin
					if (row_hit) state_d = S_RSTART;
					else if (proc_word_s1 == last_word) state_d = S_DONE;
				end
			end
			S_RSTART: state_d = S_RANGE;
			S_RANGE: begin
				if (proc_valid_s1 && (proc_word_s1 == we)) begin
					if ((mode_q == M_CHECK) && !(bad_q || bad_now)) state_d = S_RSTART;
					else state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// controller registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLR;
			clr_q         <= '0;
			proc_valid_s1 <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			proc_valid_s1 <= ((state_q == S_SCAN) || (state_q == S_RANGE)) &&
				(state_d == state_q);
			if (state_q == S_CLR) clr_q <= clr_q + MA'(1);
			if ((state_q == S_DONE) && slot_free) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		proc_word_s1 <= wc_q;
		if ((state_q == S_SCAN) || (state_q == S_RANGE)) wc_q <= wc_q + WA'(1);
		unique case (state_q)
			S_IDLE: begin
				op_q   <= req.op;
				user_q <= req.from_user_pool;
				cnt_q  <= req.page_count;
				pnum_q <= req.page_number;
				pan_q  <= req.panic_on_fail;
			end
			S_DEC: begin
				res_status_q <= bpa_pkg::ST_OK;
				res_first_q  <= '0;
				res_panic_q  <= 1'b0;
				wc_q         <= '0;
				run_start_q  <= '0;
				mode_q       <= M_CHECK;
				s_q          <= SW'(pnum_q - base_sel);
				e_q          <= SW'(pnum_q - base_sel) + cnt_w - SW'(1);
				if (op_q == bpa_pkg::OP_ALLOC) begin
					if (cnt_q == '0) begin
						res_status_q <= bpa_pkg::ST_IGNORED;
					end else if (cnt_w > size_eff) begin
						res_status_q <= bpa_pkg::ST_NOSPACE;
						res_panic_q  <= pan_q;
					end
				end else begin
					if ((cnt_q == '0) || (pnum_q == '0)) begin
						res_status_q <= bpa_pkg::ST_IGNORED;
					end else if ((pnum_q < base_sel) ||
						((FW'(pnum_q) + FW'(cnt_q)) > (FW'(base_sel) + FW'(size_eff)))) begin
						res_status_q <= bpa_pkg::ST_OUTSIDE;
					end
				end
			end
			S_SCAN: begin
				if (proc_valid_s1) begin
					run_start_q <= row_start_out;
					if (row_hit) begin
						s_q         <= row_hit_start;
						e_q         <= row_hit_start + cnt_w - SW'(1);
						mode_q      <= M_SET;
						res_first_q <= base_sel + PW'(row_hit_start);
					end else if (proc_word_s1 == last_word) begin
						res_status_q <= bpa_pkg::ST_NOSPACE;
						res_panic_q  <= pan_q;
					end
				end
			end
			S_RSTART: begin
				wc_q  <= ws;
				bad_q <= 1'b0;
			end
			S_RANGE: begin
				if (proc_valid_s1 && (mode_q == M_CHECK)) begin
					bad_q <= bad_q | bad_now;
					if (proc_word_s1 == we) begin
						if (bad_q || bad_now) res_status_q <= bpa_pkg::ST_NOTUSED;
						else mode_q <= M_CLEAR;
					end
				end
			end
			S_DONE: begin
				if (slot_free) begin
					rsp_status_q <= res_status_q;
					rsp_first_q  <= res_first_q;
					rsp_panic_q  <= res_panic_q;
				end
			end
			default: begin
			end
		endcase
	end

	// channel outputs
	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.first_page = rsp_first_q;
	assign rsp.panic      = rsp_panic_q;

	// checks
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("response raised outside done state");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("bitmap written while idle");
	a_range_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RANGE) && proc_valid_s1) |-> (proc_word_s1 <= we))
		else $error("range pass beyond last word");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |=> (state_q == S_CLR || state_q == S_IDLE))
		else $error("left clearing pass early");
endmodule
`default_nettype wire
